// ===== hdl/gfra_pkg.sv =====
// shared constants and types for the gas, flame and rain alarm controller
`timescale 1ns / 1ps

package gfra_pkg;

  // gas sensor ADC width
  localparam int ADC_BITS = 12;

  localparam int GAS_W      = 12;
  localparam int DEB_W      = 8;
  localparam int CMP_W      = (ADC_BITS > GAS_W) ? ADC_BITS : GAS_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAS_THRESHOLD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 1'd1;

  localparam logic [GAS_W-1:0] GAS_THRESHOLD_RST  = 12'd1500;
  localparam logic [DEB_W-1:0] DEBOUNCE_TICKS_RST = 8'd5;

  // one debouncer: raw level seen, run length and last reported level
  typedef struct packed {
    logic             level;
    logic [DEB_W-1:0] run;
    logic             shown_vld;
    logic             shown;
  } deb_t;

  // one result transaction
  typedef struct packed {
    logic             emergency_open;
    logic             cover_open;
    logic             gas_report;
    logic [GAS_W-1:0] gas_value;
    logic             flame_report;
    logic             flame_state;
    logic             rain_report;
    logic             rain_state;
  } result_t;

  // advance one debouncer; changed goes high when a new level is confirmed
  function automatic deb_t deb_next(input deb_t cur, input logic raw,
                                    input logic [DEB_W-1:0] ticks,
                                    output logic changed);
    deb_t             nxt;
    logic [DEB_W-1:0] run_inc;
    nxt     = cur;
    changed = 1'b0;
    run_inc = cur.run + 1'b1;
    if (raw == cur.level) begin
      nxt.run = run_inc;
      if (run_inc >= ticks) begin
        if (!cur.shown_vld || (cur.shown != cur.level)) begin
          nxt.shown_vld = 1'b1;
          nxt.shown     = cur.level;
          changed       = 1'b1;
        end
        nxt.run = '0;
      end
    end else begin
      nxt.level = raw;
      nxt.run   = '0;
    end
    return nxt;
  endfunction

endpackage

// ===== hdl/gas_flame_rain_alarm_controller.sv =====
// top level of the gas, flame and rain alarm controller
`timescale 1ns / 1ps

// Usage: one input transaction per sensor poll tick carries a gas ADC sample
// and the raw flame and rain bits (in_valid_i / in_stall_o). Each input
// transaction yields exactly one result transaction (out_valid_o /
// out_stall_i) with the emergency latch, the cover position and the gas,
// flame and rain reports. Configuration (gas threshold, debounce length) is
// written through cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle.
// An accepted transaction is held in the input register, then the compare and
// debounce logic loads the result register. Throughput is one transaction
// per cycle while out_stall_i is low, set by the single register stage
// between input and result; the input register can take one more transaction
// while a finished result waits on out_stall_i. When the receiver stalls,
// the result holds, the input register fills, and then in_stall_o rises.
// Reset clears both valid flags, the debounce runs and levels, the emergency
// and cover state and the remembered gas value, and loads the register
// defaults (threshold 1500, debounce 5 ticks).
module gas_flame_rain_alarm_controller (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gfra_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gfra_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [gfra_pkg::ADC_BITS-1:0]      gas_sample_i,
  input  logic                               flame_raw_i,
  input  logic                               rain_raw_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               emergency_open_o,
  output logic                               cover_open_o,
  output logic                               gas_report_o,
  output logic [gfra_pkg::GAS_W-1:0]         gas_value_o,
  output logic                               flame_report_o,
  output logic                               flame_state_o,
  output logic                               rain_report_o,
  output logic                               rain_state_o
);

  localparam int CmpW = gfra_pkg::CMP_W;
  localparam int GasW = gfra_pkg::GAS_W;
  localparam int DebW = gfra_pkg::DEB_W;

  // configuration
  logic [GasW-1:0] gas_thr_q;
  logic [DebW-1:0] deb_ticks_q;

  // input register
  logic                          in_valid_q;
  logic [gfra_pkg::ADC_BITS-1:0] gas_q;
  logic                          flame_q;
  logic                          rain_q;

  // block state
  gfra_pkg::deb_t                flame_deb_q, flame_deb_d;
  gfra_pkg::deb_t                rain_deb_q, rain_deb_d;
  logic                          emerg_q, emerg_d;
  logic                          cover_q, cover_d;
  logic [gfra_pkg::ADC_BITS-1:0] last_gas_q, last_gas_d;
  logic                          last_gas_vld_q, last_gas_vld_d;

  // result register
  logic              out_valid_q;
  gfra_pkg::result_t res_q, res_d;

  logic in_fire;
  logic advance;
  logic gas_low;
  logic flame_chg;
  logic rain_chg;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gas_thr_q   <= gfra_pkg::GAS_THRESHOLD_RST;
      deb_ticks_q <= gfra_pkg::DEBOUNCE_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gfra_pkg::REG_GAS_THRESHOLD:  gas_thr_q   <= cfg_data_i[GasW-1:0];
        gfra_pkg::REG_DEBOUNCE_TICKS: deb_ticks_q <= cfg_data_i[DebW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      gas_q   <= gas_sample_i;
      flame_q <= flame_raw_i;
      rain_q  <= rain_raw_i;
    end
  end

  always_comb begin
    emerg_d        = emerg_q;
    cover_d        = cover_q;
    last_gas_d     = last_gas_q;
    last_gas_vld_d = last_gas_vld_q;
    res_d          = '0;

    gas_low = CmpW'(gas_q) <= CmpW'(gas_thr_q);

    // gas check comes first in the tick
    if (!gas_low) begin
      if (!last_gas_vld_q || (gas_q != last_gas_q)) begin
        res_d.gas_report = 1'b1;
        res_d.gas_value  = GasW'(gas_q);
        last_gas_d       = gas_q;
        last_gas_vld_d   = 1'b1;
        emerg_d          = 1'b1;
      end
    end else begin
      last_gas_d     = gas_q;
      last_gas_vld_d = 1'b1;
      if (!flame_q) begin
        emerg_d = 1'b0;
      end
    end

    flame_deb_d = gfra_pkg::deb_next(flame_deb_q, flame_q, deb_ticks_q, flame_chg);
    if (flame_chg) begin
      if (flame_deb_d.shown) begin
        emerg_d = 1'b1;
      end else if (gas_low) begin
        emerg_d = 1'b0;
      end
    end

    rain_deb_d = gfra_pkg::deb_next(rain_deb_q, rain_q, deb_ticks_q, rain_chg);
    if (rain_chg) begin
      cover_d = rain_deb_d.shown;
    end

    res_d.emergency_open = emerg_d;
    res_d.cover_open     = cover_d;
    res_d.flame_report   = flame_chg;
    res_d.flame_state    = flame_deb_d.shown_vld && flame_deb_d.shown;
    res_d.rain_report    = rain_chg;
    res_d.rain_state     = rain_deb_d.shown_vld && rain_deb_d.shown;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flame_deb_q    <= '0;
      rain_deb_q     <= '0;
      emerg_q        <= 1'b0;
      cover_q        <= 1'b0;
      last_gas_q     <= '0;
      last_gas_vld_q <= 1'b0;
    end else if (advance) begin
      flame_deb_q    <= flame_deb_d;
      rain_deb_q     <= rain_deb_d;
      emerg_q        <= emerg_d;
      cover_q        <= cover_d;
      last_gas_q     <= last_gas_d;
      last_gas_vld_q <= last_gas_vld_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign emergency_open_o = res_q.emergency_open;
  assign cover_open_o     = res_q.cover_open;
  assign gas_report_o     = res_q.gas_report;
  assign gas_value_o      = res_q.gas_value;
  assign flame_report_o   = res_q.flame_report;
  assign flame_state_o    = res_q.flame_state;
  assign rain_report_o    = res_q.rain_report;
  assign rain_state_o     = res_q.rain_state;

`ifndef SYNTHESIS
  // an empty input register never holds off the sender
  a_no_stall_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("input stalled with an empty input register");

  // gas value is zero unless a report goes with it
  a_gas_value_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !gas_report_o) |-> (gas_value_o == '0))
    else $error("gas value present without a gas report");

  // a newly confirmed flame leaves the emergency latched
  a_flame_latches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && flame_report_o && flame_state_o) |-> emergency_open_o)
    else $error("confirmed flame without emergency");

  // a rain report moves the cover to the confirmed level
  a_cover_follows_rain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rain_report_o) |-> (cover_open_o == rain_state_o))
    else $error("cover does not follow reported rain level");
`endif

endmodule

// ===== bench/gfra_alarm_checker.sv =====
// alarm predictor and result checker for the gas, flame and rain alarm controller
`timescale 1ns / 1ps

module gfra_alarm_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gfra_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gfra_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [gfra_pkg::ADC_BITS-1:0]   gas_sample_i,
  input  logic                            flame_raw_i,
  input  logic                            rain_raw_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic                            emergency_open_i,
  input  logic                            cover_open_i,
  input  logic                            gas_report_i,
  input  logic [gfra_pkg::GAS_W-1:0]      gas_value_i,
  input  logic                            flame_report_i,
  input  logic                            flame_state_i,
  input  logic                            rain_report_i,
  input  logic                            rain_state_i,
  output int                              mismatch_count_o,
  output int                              alarms_waiting_o
);

  localparam int PRINT_CAP = 100;
  localparam int ADC_W     = gfra_pkg::ADC_BITS;
  localparam int GAS_W     = gfra_pkg::GAS_W;
  localparam int DEB_W     = gfra_pkg::DEB_W;

  typedef enum logic [1:0] {
    SHOWN_OFF  = 2'd0,
    SHOWN_ON   = 2'd1,
    SHOWN_NONE = 2'd2
  } shown_e;

  typedef struct packed {
    logic             level;
    logic [DEB_W-1:0] run;
    shown_e           shown;
  } sensor_deb_t;

  logic [GAS_W-1:0]    gas_limit;
  logic [DEB_W-1:0]    confirm_ticks;
  sensor_deb_t         flame_deb;
  sensor_deb_t         rain_deb;
  logic                emergency;
  logic                cover_up;
  logic                gas_seen;
  logic [ADC_W-1:0]    gas_memory;
  gfra_pkg::result_t   expected_alarms [$];

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (mismatch_count_o < PRINT_CAP) begin
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    end
    mismatch_count_o = mismatch_count_o + 1;
  endtask

  // a run of equal ticks reaching the debounce length confirms the level
  task automatic advance_debounce(input logic raw, inout sensor_deb_t st,
                                  output logic confirmed);
    logic [DEB_W-1:0] run_next;
    shown_e           level_code;
    confirmed = 1'b0;
    if (raw == st.level) begin
      run_next   = st.run + 1'b1;
      level_code = st.level ? SHOWN_ON : SHOWN_OFF;
      st.run     = run_next;
      // a length of zero passes this compare at once, same as one
      if (run_next >= confirm_ticks) begin
        if (st.shown != level_code) begin
          st.shown  = level_code;
          confirmed = 1'b1;
        end
        st.run = '0;
      end
    end else begin
      st.level = raw;
      st.run   = '0;
    end
  endtask

  task automatic predict_alarm_tick(input logic [ADC_W-1:0] gas, input logic flame,
                                    input logic rain, output gfra_pkg::result_t r);
    logic gas_low;
    logic flame_new;
    logic rain_new;
    r       = '0;
    gas_low = (gas <= gas_limit);
    if (!gas_low) begin
      if (!gas_seen || (gas != gas_memory)) begin
        r.gas_report = 1'b1;
        r.gas_value  = GAS_W'(gas);
        gas_memory   = gas;
        gas_seen     = 1'b1;
        emergency    = 1'b1;
      end
    end else begin
      gas_memory = gas;
      gas_seen   = 1'b1;
      if (!flame) begin
        emergency = 1'b0;
      end
    end
    advance_debounce(flame, flame_deb, flame_new);
    if (flame_new) begin
      r.flame_report = 1'b1;
      if (flame_deb.shown == SHOWN_ON) begin
        emergency = 1'b1;
      end else if (gas_low) begin
        emergency = 1'b0;
      end
    end
    advance_debounce(rain, rain_deb, rain_new);
    if (rain_new) begin
      r.rain_report = 1'b1;
      cover_up      = (rain_deb.shown == SHOWN_ON);
    end
    r.emergency_open = emergency;
    r.cover_open     = cover_up;
    r.flame_state    = (flame_deb.shown == SHOWN_ON);
    r.rain_state     = (rain_deb.shown == SHOWN_ON);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    gfra_pkg::result_t want;
    gfra_pkg::result_t fresh;
    if (!rst_ni) begin
      gas_limit     = gfra_pkg::GAS_THRESHOLD_RST;
      confirm_ticks = gfra_pkg::DEBOUNCE_TICKS_RST;
      flame_deb     = '{level: 1'b0, run: '0, shown: SHOWN_NONE};
      rain_deb      = '{level: 1'b0, run: '0, shown: SHOWN_NONE};
      emergency     = 1'b0;
      cover_up      = 1'b0;
      gas_seen      = 1'b0;
      gas_memory    = '0;
      expected_alarms.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_alarms.size() == 0) begin
          report_mismatch("result transaction with nothing expected", 0, 1);
        end else begin
          want = expected_alarms.pop_front();
          if (emergency_open_i !== want.emergency_open)
            report_mismatch("emergency_open", 32'(want.emergency_open),
                            32'(emergency_open_i));
          if (cover_open_i !== want.cover_open)
            report_mismatch("cover_open", 32'(want.cover_open), 32'(cover_open_i));
          if (gas_report_i !== want.gas_report)
            report_mismatch("gas_report", 32'(want.gas_report), 32'(gas_report_i));
          if (gas_value_i !== want.gas_value)
            report_mismatch("gas_value", 32'(want.gas_value), 32'(gas_value_i));
          if (flame_report_i !== want.flame_report)
            report_mismatch("flame_report", 32'(want.flame_report), 32'(flame_report_i));
          if (flame_state_i !== want.flame_state)
            report_mismatch("flame_state", 32'(want.flame_state), 32'(flame_state_i));
          if (rain_report_i !== want.rain_report)
            report_mismatch("rain_report", 32'(want.rain_report), 32'(rain_report_i));
          if (rain_state_i !== want.rain_state)
            report_mismatch("rain_state", 32'(want.rain_state), 32'(rain_state_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_alarm_tick(gas_sample_i, flame_raw_i, rain_raw_i, fresh);
        expected_alarms.push_back(fresh);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gfra_pkg::REG_GAS_THRESHOLD:  gas_limit = cfg_data_i[GAS_W-1:0];
          gfra_pkg::REG_DEBOUNCE_TICKS: confirm_ticks = cfg_data_i[DEB_W-1:0];
          default: ;
        endcase
      end
    end
    alarms_waiting_o = expected_alarms.size();
  end

endmodule

// ===== bench/gas_flame_rain_alarm_controller_tb.sv =====
// stimulus, handshake pacing and verdict for the gas, flame and rain alarm controller
`timescale 1ns / 1ps

module gas_flame_rain_alarm_controller_tb;

  localparam int ADC_W      = gfra_pkg::ADC_BITS;
  localparam int GAS_W      = gfra_pkg::GAS_W;
  localparam int DEB_W      = gfra_pkg::DEB_W;
  localparam int CFG_IDX_W  = gfra_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = gfra_pkg::CFG_DATA_W;

  localparam int N_PHASES        = 6;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int SETTLE_CYCLES   = 4;
  localparam int IDLE_LIMIT      = 1000;

  // threshold, debounce length and tick count of each random phase
  localparam int PHASE_THR   [N_PHASES] = '{4095, 2048, 0, 1000, 1500, 3000};
  localparam int PHASE_DEB   [N_PHASES] = '{1, 255, 0, 2, 5, 4};
  localparam int PHASE_TICKS [N_PHASES] = '{40, 330, 40, 40, 40, 40};
  localparam int RANDOM_PHASE = 4;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [ADC_W-1:0]      gas_sample;
  logic                  flame_raw;
  logic                  rain_raw;
  logic                  out_valid;
  logic                  out_stall;
  logic                  emergency_open;
  logic                  cover_open;
  logic                  gas_report;
  logic [GAS_W-1:0]      gas_value;
  logic                  flame_report;
  logic                  flame_state;
  logic                  rain_report;
  logic                  rain_state;
  int                    mismatch_count;
  int                    alarms_waiting;

  int unsigned           burst_left = 0;
  logic                  hold_off_req = 1'b0;

  gas_flame_rain_alarm_controller u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .gas_sample_i     (gas_sample),
    .flame_raw_i      (flame_raw),
    .rain_raw_i       (rain_raw),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .emergency_open_o (emergency_open),
    .cover_open_o     (cover_open),
    .gas_report_o     (gas_report),
    .gas_value_o      (gas_value),
    .flame_report_o   (flame_report),
    .flame_state_o    (flame_state),
    .rain_report_o    (rain_report),
    .rain_state_o     (rain_state)
  );

  gfra_alarm_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .gas_sample_i     (gas_sample),
    .flame_raw_i      (flame_raw),
    .rain_raw_i       (rain_raw),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .emergency_open_i (emergency_open),
    .cover_open_i     (cover_open),
    .gas_report_i     (gas_report),
    .gas_value_i      (gas_value),
    .flame_report_i   (flame_report),
    .flame_state_i    (flame_state),
    .rain_report_i    (rain_report),
    .rain_state_i     (rain_state),
    .mismatch_count_o (mismatch_count),
    .alarms_waiting_o (alarms_waiting)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // one poll tick per call; bursts of random length with random gaps between them
  task automatic offer_reading(input logic [ADC_W-1:0] gas, input logic flame,
                               input logic rain);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left = burst_left - 1;
    in_valid   <= 1'b1;
    gas_sample <= gas;
    flame_raw  <= flame;
    rain_raw   <= rain;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_block();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (alarms_waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input logic [GAS_W-1:0] limit, input logic [DEB_W-1:0] ticks);
    cfg_we   <= 1'b1;
    cfg_idx  <= gfra_pkg::REG_GAS_THRESHOLD;
    cfg_data <= CFG_DATA_W'(limit);
    @(posedge clk);
    cfg_idx  <= gfra_pkg::REG_DEBOUNCE_TICKS;
    cfg_data <= CFG_DATA_W'(ticks);
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // mostly runs long enough to confirm, sometimes a short glitch
  function automatic int unsigned pick_hold(input int unsigned ticks);
    int unsigned eff;
    eff = (ticks == 0) ? 1 : ticks;
    if ($urandom_range(0, 4) == 0) return $urandom_range(1, 2);
    return eff + 1 + $urandom_range(0, eff / 2 + 2);
  endfunction

  initial begin : receiver
    int unsigned mode_left;
    int unsigned stall_pct;
    logic        hold_off_done;
    mode_left     = 0;
    stall_pct     = 0;
    hold_off_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        // long hold-off so the block fills and stalls its input
        hold_off_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(10, 60);
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 20;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        mode_left = mode_left - 1;
        out_stall <= ($urandom_range(1, 100) <= stall_pct);
      end
    end
  end

  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
      else idle_run = idle_run + 1;
    end
    $display("gas_flame_rain_alarm_controller_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    int unsigned         thr_now;
    int unsigned         deb_now;
    int unsigned         flame_hold;
    int unsigned         rain_hold;
    logic                flame_lvl;
    logic                rain_lvl;
    logic [ADC_W-1:0]    gas;
    logic [ADC_W-1:0]    last_gas_sent;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_idx    <= gfra_pkg::REG_GAS_THRESHOLD;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    gas_sample <= '0;
    flame_raw  <= 1'b0;
    rain_raw   <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed ticks at the reset settings: threshold 1500, five ticks
    offer_reading(12'd4095, 1'b0, 1'b0);  // first high sample always reported
    offer_reading(12'd4095, 1'b0, 1'b0);  // repeated high value stays quiet
    offer_reading(12'd1501, 1'b0, 1'b0);
    offer_reading(12'd1500, 1'b0, 1'b0);  // at threshold is low, clears without flame
    offer_reading(12'd2000, 1'b0, 1'b0);  // both levels confirmed low here
    offer_reading(12'd0, 1'b0, 1'b0);
    offer_reading(12'd2000, 1'b1, 1'b1);  // high again after a low sample
    repeat (5) offer_reading(12'd100, 1'b1, 1'b1);  // raw flame keeps the latch
    offer_reading(12'd2000, 1'b1, 1'b1);
    repeat (6) offer_reading(12'd1500, 1'b0, 1'b0);
    offer_reading(12'hAAA, 1'b0, 1'b0);
    offer_reading(12'h555, 1'b0, 1'b0);

    flame_hold    = 0;
    rain_hold     = 0;
    flame_lvl     = 1'b0;
    rain_lvl      = 1'b0;
    last_gas_sent = 12'h555;
    for (int p = 0; p < N_PHASES; p++) begin
      drain_block();
      thr_now = (p == RANDOM_PHASE) ? $urandom_range(0, 4095) : PHASE_THR[p];
      deb_now = (p == RANDOM_PHASE) ? $urandom_range(1, 8) : PHASE_DEB[p];
      load_settings(GAS_W'(thr_now), DEB_W'(deb_now));
      if (p == 0) hold_off_req = 1'b1;
      repeat (PHASE_TICKS[p]) begin
        if (flame_hold == 0) begin
          flame_lvl  = ~flame_lvl;
          flame_hold = pick_hold(deb_now);
        end
        if (rain_hold == 0) begin
          rain_lvl  = ~rain_lvl;
          rain_hold = pick_hold(deb_now);
        end
        flame_hold = flame_hold - 1;
        rain_hold  = rain_hold - 1;
        case ($urandom_range(0, 9))
          0:       gas = '0;
          1:       gas = '1;
          2:       gas = ADC_W'(thr_now);
          3:       gas = ADC_W'((thr_now == 4095) ? thr_now : thr_now + 1);
          4:       gas = ADC_W'((thr_now == 0) ? 0 : thr_now - 1);
          5, 6:    gas = last_gas_sent;
          default: gas = ADC_W'($urandom_range(0, 4095));
        endcase
        offer_reading(gas, flame_lvl, rain_lvl);
        last_gas_sent = gas;
      end
    end
    drain_block();

    if ((mismatch_count == 0) && (alarms_waiting == 0)) begin
      $display("gas_flame_rain_alarm_controller_tb OK");
    end else begin
      $display("gas_flame_rain_alarm_controller_tb NOT OK");
    end
    $finish;
  end

endmodule
